@@ rtl/laplacian_edge_filter_defines.svh @@
// assertion macros shared by the laplacian edge filter modules
// expects signals named clk and rst_n in the module that uses them
`ifndef LAPLACIAN_EDGE_FILTER_DEFINES_SVH
`define LAPLACIAN_EDGE_FILTER_DEFINES_SVH

// same-cycle implication
`define LEF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LEF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lef_pkg.sv @@
// shared types, constants and mask arithmetic for the laplacian edge filter
// no dependencies
package lef_pkg;

    localparam int unsigned MAX_WIDTH_DEF = 2048;
    localparam int unsigned HEIGHT_LIMIT  = 4096;
    localparam int unsigned PIX_W         = 8;
    localparam int unsigned WIDTH_REG_W   = 12;
    localparam int unsigned HEIGHT_REG_W  = 13;
    localparam int unsigned ROW_W         = 12;
    localparam int unsigned IN_ROW_W      = 13;
    localparam int unsigned PADDR_W       = 4;
    localparam int unsigned PDATA_W       = 32;
    localparam int unsigned OUT_DEPTH     = 4;
    localparam int unsigned CNT_W         = $clog2(OUT_DEPTH + 1);
    localparam int unsigned PTR_W         = $clog2(OUT_DEPTH);
    localparam int unsigned SUM_W         = 12;
    localparam int unsigned SATURATION    = 255;
    localparam int unsigned WIDTH_RESET   = 640;
    localparam int unsigned HEIGHT_RESET  = 480;

    typedef enum logic [1:0] {
        MASK_FOUR  = 2'd0,
        MASK_EIGHT = 2'd1,
        MASK_DIAG  = 2'd2
    } mask_t;

    typedef enum logic [1:0] {
        REG_MASK   = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } reg_idx_t;

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    typedef struct packed {
        logic [1:0]              mask_sel;
        logic [WIDTH_REG_W-1:0]  width;
        logic [HEIGHT_REG_W-1:0] height;
        logic                    restart;
    } lef_cfg_t;

    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] px;
        logic             gate_up;
        logic             gate_mid;
        logic             emit;
        logic             last;
        logic             clear;
        logic             top;
        logic             bot;
        logic             left;
        logic             right;
    } lef_req_t;

    typedef struct packed {
        logic                        valid;
        logic                        last;
        logic [2:0][2:0][PIX_W-1:0]  px;
    } lef_emit_t;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             frame_last;
    } lef_result_t;

    // weighted contribution of one window pixel under the selected mask
    function automatic logic signed [SUM_W-1:0] lef_term(
        input logic [1:0]       sel,
        input logic [1:0]       r,
        input logic [1:0]       c,
        input logic [PIX_W-1:0] px
    );
        logic signed [SUM_W-1:0] p;
        logic                    center;
        logic                    corner;
        logic signed [SUM_W-1:0] term;
        p      = $signed(SUM_W'(px));
        center = (r == 2'd1) && (c == 2'd1);
        corner = (r != 2'd1) && (c != 2'd1);
        case (sel)
            MASK_EIGHT: term = center ? (p <<< 3) : -p;
            MASK_DIAG:  term = center ? (p <<< 2) : (corner ? p : -(p <<< 1));
            default:    term = center ? (p <<< 2) : (corner ? '0 : -p);
        endcase
        return term;
    endfunction

endpackage

@@ rtl/lef_pixel_if.sv @@
// input channel: opcode and pixel with valid/ready
// uses lef_pkg for the pixel width
interface lef_pixel_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [lef_pkg::PIX_W-1:0]  pixel_value;

    modport source (output valid, output opcode, output pixel_value, input ready);
    modport sink   (input valid, input opcode, input pixel_value, output ready);
endinterface

@@ rtl/lef_edge_if.sv @@
// output channel: edge magnitude and end-of-frame flag with valid/ready
// uses lef_pkg for the pixel width
interface lef_edge_if;
    logic                       valid;
    logic                       ready;
    logic [lef_pkg::PIX_W-1:0]  edge_value;
    logic                       frame_last;

    modport source (output valid, output edge_value, output frame_last, input ready);
    modport sink   (input valid, input edge_value, input frame_last, output ready);
endinterface

@@ rtl/lef_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// no dependencies beyond lef_pkg defaults
module lef_ram #(
    parameter int unsigned WIDTH = 2 * lef_pkg::PIX_W,
    parameter int unsigned DEPTH = lef_pkg::MAX_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/lef_regs.sv @@
// apb configuration registers: mask select, image width, image height
// uses lef_pkg for register codes and the config struct
module lef_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lef_pkg::PADDR_W-1:0]   paddr,
    input  logic [lef_pkg::PDATA_W-1:0]   pwdata,
    output logic [lef_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output lef_pkg::lef_cfg_t             cfg
);

    logic [1:0]                         mask_reg;
    logic [1:0]                         mask_next;
    logic [lef_pkg::WIDTH_REG_W-1:0]    width_reg;
    logic [lef_pkg::WIDTH_REG_W-1:0]    width_next;
    logic [lef_pkg::HEIGHT_REG_W-1:0]   height_reg;
    logic [lef_pkg::HEIGHT_REG_W-1:0]   height_next;
    logic                               wr;
    lef_pkg::reg_idx_t                  idx;
    logic                               restart;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = lef_pkg::reg_idx_t'(paddr[lef_pkg::PADDR_W-1:2]);

    always_comb
    begin
        mask_next   = mask_reg;
        width_next  = width_reg;
        height_next = height_reg;
        restart     = 1'b0;
        if (wr)
        begin
            case (idx)
                lef_pkg::REG_MASK:   mask_next = pwdata[1:0];
                lef_pkg::REG_WIDTH:
                begin
                    width_next = pwdata[lef_pkg::WIDTH_REG_W-1:0];
                    restart    = 1'b1;
                end
                lef_pkg::REG_HEIGHT:
                begin
                    height_next = pwdata[lef_pkg::HEIGHT_REG_W-1:0];
                    restart     = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= lef_pkg::MASK_FOUR;
            width_reg  <= lef_pkg::WIDTH_REG_W'(lef_pkg::WIDTH_RESET);
            height_reg <= lef_pkg::HEIGHT_REG_W'(lef_pkg::HEIGHT_RESET);
        end
        else
        begin
            mask_reg   <= mask_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    always_comb
    begin
        case (idx)
            lef_pkg::REG_MASK:   prdata = lef_pkg::PDATA_W'(mask_reg);
            lef_pkg::REG_WIDTH:  prdata = lef_pkg::PDATA_W'(width_reg);
            lef_pkg::REG_HEIGHT: prdata = lef_pkg::PDATA_W'(height_reg);
            default:             prdata = '0;
        endcase
    end

    assign cfg.mask_sel = mask_reg;
    assign cfg.width    = width_reg;
    assign cfg.height   = height_reg;
    assign cfg.restart  = restart;

endmodule

@@ rtl/lef_ctrl.sv @@
// issue stage: raster counters, border flags and at most one line-store access per cycle
// uses lef_pkg types, the pixel interface and the assertion macros
`include "laplacian_edge_filter_defines.svh"

module lef_ctrl #(
    parameter int unsigned MAX_WIDTH = lef_pkg::MAX_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lef_pkg::lef_cfg_t           cfg,
    input  logic                        room,
    lef_pixel_if.sink                   pixel_stream,
    output lef_pkg::lef_req_t           req,
    output logic [$clog2(MAX_WIDTH)-1:0] req_addr
);

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);

    logic [COL_W-1:0]              in_col_reg;
    logic [COL_W-1:0]              in_col_next;
    logic [lef_pkg::IN_ROW_W-1:0]  in_row_reg;
    logic [lef_pkg::IN_ROW_W-1:0]  in_row_next;
    logic [COL_W-1:0]              out_col_reg;
    logic [COL_W-1:0]              out_col_next;
    logic [lef_pkg::ROW_W-1:0]     out_row_reg;
    logic [lef_pkg::ROW_W-1:0]     out_row_next;
    logic [COL_W-1:0]              last_col;
    logic [lef_pkg::ROW_W-1:0]     last_row;
    logic                          active;
    logic                          ready_cond;
    logic                          take;
    logic                          pre;
    logic                          real_op;
    logic                          do_shift;
    logic                          emit;
    logic                          last;

    // effective frame size
    always_comb
    begin
        if (cfg.width == '0)
        begin
            last_col = '0;
        end
        else if (32'(cfg.width) > 32'(MAX_WIDTH))
        begin
            last_col = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = COL_W'(cfg.width - lef_pkg::WIDTH_REG_W'(1));
        end

        if (cfg.height == '0)
        begin
            last_row = '0;
        end
        else if (32'(cfg.height) > 32'(lef_pkg::HEIGHT_LIMIT))
        begin
            last_row = lef_pkg::ROW_W'(lef_pkg::HEIGHT_LIMIT - 1);
        end
        else
        begin
            last_row = lef_pkg::ROW_W'(cfg.height - lef_pkg::HEIGHT_REG_W'(1));
        end
    end

    assign active     = in_row_reg <= {1'b0, last_row};
    assign ready_cond = (in_row_reg >= lef_pkg::IN_ROW_W'(2))
                     || ((in_row_reg == lef_pkg::IN_ROW_W'(1)) && (in_col_reg != '0));

    // a drain that needs a leading phantom shift holds ready low for one cycle
    assign pixel_stream.ready = room && (active || ready_cond);
    assign take     = pixel_stream.valid && pixel_stream.ready;
    assign pre      = pixel_stream.valid && room && !active && !ready_cond;
    assign real_op  = take && (!active || (pixel_stream.opcode == lef_pkg::OP_PUSH));
    assign do_shift = real_op || pre;
    assign emit     = real_op && ready_cond;
    assign last     = (out_row_reg >= last_row) && (out_col_reg >= last_col);

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg.restart || (emit && last))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else
        begin
            if (do_shift)
            begin
                if (in_col_reg == last_col)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + lef_pkg::IN_ROW_W'(1);
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
            end
            if (emit)
            begin
                if (out_col_reg == last_col)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + lef_pkg::ROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    always_comb
    begin
        req.valid    = do_shift;
        req.px       = (active && take) ? pixel_stream.pixel_value : '0;
        req.gate_up  = in_row_reg >= lef_pkg::IN_ROW_W'(2);
        req.gate_mid = in_row_reg != '0;
        req.emit     = emit;
        req.last     = last;
        req.clear    = emit && last;
        req.top      = out_row_reg == '0;
        req.bot      = out_row_reg >= last_row;
        req.left     = out_col_reg == '0;
        req.right    = out_col_reg >= last_col;
    end

    assign req_addr = in_col_reg;

    `LEF_ASSERT_NEXT(a_frame_restart, req.valid && req.clear, (in_col_reg == '0) && (in_row_reg == '0) && (out_col_reg == '0) && (out_row_reg == '0), "counters not cleared after final result")

endmodule

@@ rtl/lef_window.sv @@
// line-store read/modify/write with forwarding, 3x3 window and border masking
// uses lef_pkg types, lef_ram and the assertion macros
`include "laplacian_edge_filter_defines.svh"

module lef_window #(
    parameter int unsigned MAX_WIDTH = lef_pkg::MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         restart,
    input  lef_pkg::lef_req_t            req,
    input  logic [$clog2(MAX_WIDTH)-1:0] req_addr,
    output logic                         pend_emit,
    output lef_pkg::lef_emit_t           emit
);

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    localparam int unsigned LINE_W = 2 * lef_pkg::PIX_W;

    lef_pkg::lef_req_t                          s2_reg;
    logic [COL_W-1:0]                           s2_addr_reg;
    logic                                       fwd_hit_reg;
    logic                                       fwd_hit_next;
    logic [LINE_W-1:0]                          fwd_data_reg;
    logic [2:0][2:0][lef_pkg::PIX_W-1:0]        win_reg;
    logic [2:0][2:0][lef_pkg::PIX_W-1:0]        win_next;
    logic [2:0][2:0][lef_pkg::PIX_W-1:0]        shifted;
    lef_pkg::lef_emit_t                         emit_reg;
    lef_pkg::lef_emit_t                         emit_next;
    logic [LINE_W-1:0]                          ram_rdata;
    logic [LINE_W-1:0]                          line_data;
    logic [LINE_W-1:0]                          wdata;
    logic [2:0][lef_pkg::PIX_W-1:0]             col_new;

    // one entry holds {upper row, middle row} for a column
    lef_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s2_reg.valid),
        .waddr (s2_addr_reg),
        .wdata (wdata),
        .re    (req.valid),
        .raddr (req_addr),
        .rdata (ram_rdata)
    );

    assign line_data = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    always_comb
    begin
        col_new[0] = s2_reg.gate_up  ? line_data[LINE_W-1:lef_pkg::PIX_W] : '0;
        col_new[1] = s2_reg.gate_mid ? line_data[lef_pkg::PIX_W-1:0]      : '0;
        col_new[2] = s2_reg.px;
        wdata      = {col_new[1], col_new[2]};
        for (int r = 0; r < 3; r++)
        begin
            shifted[r][0] = win_reg[r][1];
            shifted[r][1] = win_reg[r][2];
            shifted[r][2] = col_new[r];
        end
    end

    // same column issued last cycle is still in flight at the ram
    assign fwd_hit_next = req.valid && s2_reg.valid && (req_addr == s2_addr_reg);

    always_comb
    begin
        if (restart)
        begin
            win_next = '0;
        end
        else if (s2_reg.valid)
        begin
            win_next = s2_reg.clear ? '0 : shifted;
        end
        else
        begin
            win_next = win_reg;
        end

        emit_next.valid = s2_reg.valid && s2_reg.emit;
        emit_next.last  = s2_reg.last;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (((r == 0) && s2_reg.top) || ((r == 2) && s2_reg.bot)
                    || ((c == 0) && s2_reg.left) || ((c == 2) && s2_reg.right))
                begin
                    emit_next.px[r][c] = '0;
                end
                else
                begin
                    emit_next.px[r][c] = shifted[r][c];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg      <= '0;
            fwd_hit_reg <= 1'b0;
            win_reg     <= '0;
            emit_reg    <= '0;
        end
        else
        begin
            s2_reg      <= req;
            fwd_hit_reg <= fwd_hit_next;
            win_reg     <= win_next;
            emit_reg    <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_addr_reg  <= req_addr;
        fwd_data_reg <= wdata;
    end

    assign pend_emit = s2_reg.valid && s2_reg.emit;
    assign emit      = emit_reg;

    `LEF_ASSERT_IMPL(a_fwd_has_writer, fwd_hit_reg, s2_reg.valid, "forward without a shift in flight")
    `LEF_ASSERT_NEXT(a_restart_clears, restart, win_reg == '0, "window not cleared on restart")

endmodule

@@ rtl/lef_kernel.sv @@
// mask sum, magnitude and saturation, then the result queue feeding the output
// uses lef_pkg types and functions, the edge interface and the assertion macros
`include "laplacian_edge_filter_defines.svh"

module lef_kernel (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [1:0]                  mask_sel,
    input  lef_pkg::lef_emit_t          emit,
    lef_edge_if.source                  edge_stream,
    output logic [lef_pkg::CNT_W-1:0]   count
);

    logic signed [lef_pkg::SUM_W-1:0]   sum;
    logic [lef_pkg::SUM_W-1:0]          mag;
    lef_pkg::lef_result_t               res;
    lef_pkg::lef_result_t               q_reg [lef_pkg::OUT_DEPTH];
    logic [lef_pkg::PTR_W-1:0]          wr_ptr_reg;
    logic [lef_pkg::PTR_W-1:0]          wr_ptr_next;
    logic [lef_pkg::PTR_W-1:0]          rd_ptr_reg;
    logic [lef_pkg::PTR_W-1:0]          rd_ptr_next;
    logic [lef_pkg::CNT_W-1:0]          count_reg;
    logic [lef_pkg::CNT_W-1:0]          count_next;
    logic                               push;
    logic                               pop;

    always_comb
    begin
        sum = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sum = sum + lef_pkg::lef_term(mask_sel, 2'(r), 2'(c), emit.px[r][c]);
            end
        end
        mag = sum[lef_pkg::SUM_W-1] ? $unsigned(-sum) : $unsigned(sum);
        if (mag > lef_pkg::SUM_W'(lef_pkg::SATURATION))
        begin
            res.edge_value = lef_pkg::PIX_W'(lef_pkg::SATURATION);
        end
        else
        begin
            res.edge_value = mag[lef_pkg::PIX_W-1:0];
        end
        res.frame_last = emit.last;
    end

    assign push = emit.valid;
    assign pop  = edge_stream.valid && edge_stream.ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + lef_pkg::PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + lef_pkg::PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + lef_pkg::CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - lef_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= res;
        end
    end

    assign edge_stream.valid      = count_reg != '0;
    assign edge_stream.edge_value = q_reg[rd_ptr_reg].edge_value;
    assign edge_stream.frame_last = q_reg[rd_ptr_reg].frame_last;
    assign count                  = count_reg;

    `LEF_ASSERT_IMPL(a_no_overflow, push, count_reg != lef_pkg::CNT_W'(lef_pkg::OUT_DEPTH), "result queue overflow")
    `LEF_ASSERT_NEXT(a_count_grows, push && !pop, count_reg == $past(count_reg) + lef_pkg::CNT_W'(1), "queue count did not advance")

endmodule

@@ rtl/laplacian_edge_filter.sv @@
// top level of the 3x3 laplacian edge filter: config registers, issue, window, kernel
// depends on lef_pkg, lef_pixel_if, lef_edge_if, lef_regs, lef_ctrl, lef_window, lef_kernel
//
//  port          | dir  | transfer            | payload
//  --------------+------+---------------------+------------------------------------
//  pixel_stream  | sink | valid & ready       | opcode, pixel_value
//  edge_stream   | src  | valid & ready       | edge_value, frame_last
//  apb (p*)      | sink | psel&penable&pwrite | paddr, pwdata -> prdata
//
// one item per cycle while there is room; results pass s2_reg, emit_reg and the queue
// the first drain after a single-row image is preceded by one extra phantom shift
// the line store is one ram read and written at most once per cycle, with forwarding
// ready drops while queued plus in-flight results fill the four-entry output queue
// async reset clears counters, window and queue; the line ram is not cleared
module laplacian_edge_filter #(
    parameter int unsigned MAX_WIDTH = lef_pkg::MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lef_pkg::PADDR_W-1:0]  paddr,
    input  logic [lef_pkg::PDATA_W-1:0]  pwdata,
    output logic [lef_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    lef_pixel_if.sink                    pixel_stream,
    lef_edge_if.source                   edge_stream
);

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);

    lef_pkg::lef_cfg_t          cfg;
    lef_pkg::lef_req_t          req;
    logic [COL_W-1:0]           req_addr;
    logic                       pend_emit;
    lef_pkg::lef_emit_t         emit_bus;
    logic [lef_pkg::CNT_W-1:0]  q_count;
    logic [lef_pkg::CNT_W-1:0]  occupancy;
    logic                       room;

    assign occupancy = q_count + lef_pkg::CNT_W'(pend_emit) + lef_pkg::CNT_W'(emit_bus.valid);
    assign room      = occupancy < lef_pkg::CNT_W'(lef_pkg::OUT_DEPTH);

    lef_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lef_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .room         (room),
        .pixel_stream (pixel_stream),
        .req          (req),
        .req_addr     (req_addr)
    );

    lef_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (cfg.restart),
        .req       (req),
        .req_addr  (req_addr),
        .pend_emit (pend_emit),
        .emit      (emit_bus)
    );

    lef_kernel u_kernel (
        .clk         (clk),
        .rst_n       (rst_n),
        .mask_sel    (cfg.mask_sel),
        .emit        (emit_bus),
        .edge_stream (edge_stream),
        .count       (q_count)
    );

endmodule
